[hw/rtl/dcwa_pkg.sv]
// Shared types and constants for the dual-channel window averager.
package dcwa_pkg;

    localparam int SMP_W = 10;  // converter sample width
    localparam int QUO_W = 10;  // average width

    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_REPORT = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WALK,
        S_DRAIN,
        S_DIV,
        S_DONE
    } t_state;

    typedef struct packed {
        logic wr_en;       // store the accepted sample
        logic walk_start;  // load read pointers, clear sums
        logic walk_step;   // read one entry of each ring
        logic div_step;    // register both quotients
        logic load_out;    // move quotients to the output register
    } t_dp_cmd;

    typedef struct packed {
        logic out_valid;
    } t_dp_status;

endpackage

[hw/rtl/dcwa_req_if.sv]
// Request channel: command and sample with valid/ready.
interface dcwa_req_if;
    logic       valid;
    logic       ready;
    logic       command;
    logic [9:0] sample;

    modport source (output valid, output command, output sample, input ready);
    modport sink   (input valid, input command, input sample, output ready);
endinterface

[hw/rtl/dcwa_rsp_if.sv]
// Result channel: both channel averages with valid/ready.
interface dcwa_rsp_if;
    logic       valid;
    logic       ready;
    logic [9:0] average_zero;
    logic [9:0] average_one;

    modport source (output valid, output average_zero, output average_one, input ready);
    modport sink   (input valid, input average_zero, input average_one, output ready);
endinterface

[hw/rtl/dual_channel_window_averager_top.sv]
// Top level of the dual-channel window averager: controller plus datapath.
// Sequence: a sample request is accepted whenever the controller is idle; a report request
//   gives its result after WINDOW ring reads, a drain step, a divide step and a load.
// Throughput: samples 1 per cycle while idle; a report holds off new requests until its
//   result is loaded (one read port per ring), longer while an earlier result is not taken.
// Reset (synchronous, active low): toggle to channel 1, write indices to 0, rings read as zero.
module dual_channel_window_averager_top #(
    parameter int RING_DEPTH = 1024,
    parameter int WINDOW     = 128
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    dcwa_req_if.sink          i_req,
    dcwa_rsp_if.source        o_rsp
);
    import dcwa_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;

    // Sequence each request: store a sample, or walk both rings and divide.
    dcwa_ctrl #(
        .WINDOW (WINDOW)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_req.valid),
        .i_in_command (i_req.command),
        .o_in_ready   (i_req.ready),
        .i_status     (status),
        .o_cmd        (cmd)
    );

    // Hold the rings, accumulate the window, divide, and register the averages.
    // The output register lets the next request enter while a result waits.
    dcwa_datapath #(
        .RING_DEPTH (RING_DEPTH),
        .WINDOW     (WINDOW)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_sample    (i_req.sample),
        .i_out_ready (o_rsp.ready),
        .o_status    (status),
        .o_out_valid (o_rsp.valid),
        .o_avg_zero  (o_rsp.average_zero),
        .o_avg_one   (o_rsp.average_one)
    );

endmodule

[hw/rtl/dcwa_datapath.sv]
// Datapath: ring memories, window accumulators, reciprocal divide, output register.
module dcwa_datapath #(
    parameter int RING_DEPTH = 1024,
    parameter int WINDOW     = 128
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  dcwa_pkg::t_dp_cmd            i_cmd,
    input  logic [dcwa_pkg::SMP_W-1:0]   i_sample,
    input  logic                         i_out_ready,
    output dcwa_pkg::t_dp_status         o_status,
    output logic                         o_out_valid,
    output logic [dcwa_pkg::QUO_W-1:0]   o_avg_zero,
    output logic [dcwa_pkg::QUO_W-1:0]   o_avg_one
);
    import dcwa_pkg::*;

    localparam int IW = $clog2(RING_DEPTH);
    localparam int SW = SMP_W + $clog2(WINDOW);
    localparam logic [IW-1:0] LAST_IDX = IW'(RING_DEPTH - 1);
    // Floor divide by WINDOW: multiply by the rounded-up reciprocal, drop the fraction bits.
    localparam int DIV_SH = SW + $clog2(WINDOW);
    localparam int PW     = 2 * SW + 1;
    localparam logic [SW:0] RECIP =
        (SW+1)'(((64'd1 << DIV_SH) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));

    logic [SMP_W-1:0] mem_zero [RING_DEPTH];
    logic [SMP_W-1:0] mem_one  [RING_DEPTH];

    logic             r_toggle;
    logic [IW-1:0]    r_wr_idx0, r_wr_idx1;
    logic             r_wrapped0, r_wrapped1;
    logic [IW-1:0]    r_addr0, r_addr1;
    logic [SMP_W-1:0] r_rd0, r_rd1;
    logic             r_vld0, r_vld1;
    logic             r_acc_en;
    logic [SW-1:0]    r_sum0, r_sum1;
    logic [QUO_W-1:0] r_q0, r_q1;
    logic             r_out_valid;
    logic [QUO_W-1:0] r_avg0, r_avg1;

    logic [IW-1:0]    n_wr_idx0, n_wr_idx1;
    logic [IW-1:0]    n_start0, n_start1;
    logic [IW-1:0]    n_addr0, n_addr1;
    logic [PW-1:0]    prod0, prod1;

    // Index arithmetic with wrap at the ring depth.
    always_comb begin
        n_wr_idx0 = (r_wr_idx0 == LAST_IDX) ? '0 : r_wr_idx0 + 1'b1;
        n_wr_idx1 = (r_wr_idx1 == LAST_IDX) ? '0 : r_wr_idx1 + 1'b1;
        n_start0  = (r_wr_idx0 == '0) ? LAST_IDX : r_wr_idx0 - 1'b1;
        n_start1  = (r_wr_idx1 == '0) ? LAST_IDX : r_wr_idx1 - 1'b1;
        n_addr0   = (r_addr0 == '0) ? LAST_IDX : r_addr0 - 1'b1;
        n_addr1   = (r_addr1 == '0) ? LAST_IDX : r_addr1 - 1'b1;
        prod0     = PW'(r_sum0) * PW'(RECIP);
        prod1     = PW'(r_sum1) * PW'(RECIP);
    end

    // Control state: toggle, write indices, fill marks, valid flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_toggle    <= 1'b1;
            r_wr_idx0   <= '0;
            r_wr_idx1   <= '0;
            r_wrapped0  <= 1'b0;
            r_wrapped1  <= 1'b0;
            r_acc_en    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_acc_en <= i_cmd.walk_step;
            if (i_cmd.wr_en) begin
                r_toggle <= ~r_toggle;
                if (!r_toggle) begin
                    r_wr_idx0 <= n_wr_idx0;
                    if (r_wr_idx0 == LAST_IDX) begin
                        r_wrapped0 <= 1'b1;
                    end
                end else begin
                    r_wr_idx1 <= n_wr_idx1;
                    if (r_wr_idx1 == LAST_IDX) begin
                        r_wrapped1 <= 1'b1;
                    end
                end
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Ring memories: one write port, one registered read port each.
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en && !r_toggle) begin
            mem_zero[r_wr_idx0] <= i_sample;
        end
        if (i_cmd.wr_en && r_toggle) begin
            mem_one[r_wr_idx1] <= i_sample;
        end
        r_rd0 <= mem_zero[r_addr0];
        r_rd1 <= mem_one[r_addr1];
    end

    // Walk, accumulate, divide and load the output; entries never written count as zero.
    always_ff @(posedge i_clk) begin
        if (i_cmd.walk_start) begin
            r_addr0 <= n_start0;
            r_addr1 <= n_start1;
            r_sum0  <= '0;
            r_sum1  <= '0;
        end else if (i_cmd.walk_step) begin
            r_addr0 <= n_addr0;
            r_addr1 <= n_addr1;
        end
        if (i_cmd.walk_step) begin
            r_vld0 <= r_wrapped0 || (r_addr0 < r_wr_idx0);
            r_vld1 <= r_wrapped1 || (r_addr1 < r_wr_idx1);
        end
        if (r_acc_en) begin
            r_sum0 <= r_sum0 + (r_vld0 ? SW'(r_rd0) : '0);
            r_sum1 <= r_sum1 + (r_vld1 ? SW'(r_rd1) : '0);
        end
        if (i_cmd.div_step) begin
            r_q0 <= prod0[DIV_SH +: QUO_W];
            r_q1 <= prod1[DIV_SH +: QUO_W];
        end
        if (i_cmd.load_out) begin
            r_avg0 <= r_q0;
            r_avg1 <= r_q1;
        end
    end

    assign o_status.out_valid = r_out_valid;
    assign o_out_valid        = r_out_valid;
    assign o_avg_zero         = r_avg0;
    assign o_avg_one          = r_avg1;

`ifndef SYNTH
    a_toggle_flips: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.wr_en |=> (r_toggle != $past(r_toggle)))
        else $error("channel toggle did not flip on a sample write");
    a_acc_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_acc_en |-> $past(i_cmd.walk_step))
        else $error("accumulate without a preceding ring read");
    a_no_write_in_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.walk_step || r_acc_en) |-> !i_cmd.wr_en)
        else $error("ring written during a window walk");
`endif

endmodule

[hw/rtl/dcwa_ctrl.sv]
// Controller: sequences sample writes, window walk, division and result hand-off.
module dcwa_ctrl #(
    parameter int WINDOW = 128
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_command,
    output logic                 o_in_ready,
    input  dcwa_pkg::t_dp_status i_status,
    output dcwa_pkg::t_dp_cmd    o_cmd
);
    import dcwa_pkg::*;

    localparam int CNT_W = ($clog2(WINDOW) > 1) ? $clog2(WINDOW) : 1;
    localparam logic [CNT_W-1:0] WALK_LAST = CNT_W'(WINDOW - 1);

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid && i_in_command == CMD_SAMPLE) begin
                    o_cmd.wr_en = 1'b1;
                end
                if (i_in_valid && i_in_command == CMD_REPORT) begin
                    o_cmd.walk_start = 1'b1;
                    n_cnt            = '0;
                    n_state          = S_WALK;
                end
            end
            S_WALK: begin
                o_cmd.walk_step = 1'b1;
                n_cnt           = r_cnt + 1'b1;
                if (r_cnt == WALK_LAST) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                // last entry lands in the sums this cycle
                n_state = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_state        = S_DONE;
            end
            S_DONE: begin
                if (!i_status.out_valid) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

`ifndef SYNTH
    a_report_walks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_in_command == CMD_REPORT) |=> (r_state == S_WALK))
        else $error("report request did not start a window walk");
    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |-> !i_status.out_valid)
        else $error("output register overwritten before it was taken");
    a_walk_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK && n_state == S_DRAIN) |-> (r_cnt == WALK_LAST))
        else $error("window walk ended after the wrong number of reads");
`endif

endmodule
